// File: rtl/assert_macros.svh
// Assertion macros for the touch event ring RTL.
// Used by files that include this header; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clk edge outside reset.
`define TER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ter_pkg.sv
// Package for the touch event ring: sizes, codes, event record and the
// controller/datapath interface structs. No dependencies.
package ter_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = 32;
  localparam int COORD_W    = 16;
  localparam int PANEL_W    = 12;
  localparam int VALUE_W    = 12;
  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int TIME_W     = 64;
  localparam int TYPE_W     = 2;
  localparam int CODE_W     = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [USEC_W-1:0] US_PER_SEC = 20'd1000000;

  // Seconds split: 1000000 = 64 * 15625. t >> 6 is divided by 15625 one
  // 16-bit digit at a time, each digit by a reciprocal multiply for the
  // digit, then a multiply back and subtract for the partial remainder.
  localparam int DIV_SHIFT   = 6;
  localparam int DIV_ODD_W   = 14;
  localparam logic [DIV_ODD_W-1:0] DIV_ODD = 14'd15625;
  localparam int DIV_DIGIT_W = 16;
  localparam int DIV_NUM_W   = DIV_ODD_W + DIV_DIGIT_W;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 44;
  // ceil(2^44 / 15625), exact for every 30-bit numerator
  localparam logic [RECIP_W-1:0] RECIP_M = 31'd1125899907;
  localparam int DIV_PROD_W  = DIV_NUM_W + RECIP_W;
  localparam int DIV_STEPS   = 2 * (TIME_W / DIV_DIGIT_W);
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RESET  = 12'd480;
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RESET = 12'd272;

  // evdev types and codes
  localparam logic [TYPE_W-1:0] EV_SYN = 2'd0;
  localparam logic [TYPE_W-1:0] EV_KEY = 2'd1;
  localparam logic [TYPE_W-1:0] EV_ABS = 2'd3;
  localparam logic [CODE_W-1:0] CODE_ABS_X      = 9'd0;
  localparam logic [CODE_W-1:0] CODE_ABS_Y      = 9'd1;
  localparam logic [CODE_W-1:0] CODE_BTN_TOUCH  = 9'd330;
  localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 9'd0;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_POLL   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DELIVERED   = 2'd0,
    ST_WOULD_BLOCK = 2'd1,
    ST_POLL        = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_ABS_X = 2'd0,
    KIND_ABS_Y = 2'd1,
    KIND_TOUCH = 2'd2,
    KIND_SYNC  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANEL_WIDTH  = 1'b0,
    CFG_PANEL_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WR_X,
    S_WR_Y,
    S_WR_TOUCH,
    S_WR_SYNC,
    S_RD_CHECK,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [SEC_W-1:0]    seconds;
    logic [USEC_W-1:0]   micro;
  } event_t;

  typedef struct packed {
    logic  capture;
    logic  div_start;
    logic  open;
    logic  lap;
    logic  wr_en;
    kind_t wr_kind;
    logic  rd_issue;
    logic  out_poll;
    logic  out_block;
    logic  out_event;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
  } dp_status_t;

  function automatic logic [VALUE_W-1:0] clamp_axis(
    input logic signed [COORD_W-1:0] v,
    input logic [PANEL_W-1:0]        size
  );
    logic [VALUE_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v[COORD_W-2:0] >= (COORD_W-1)'(size)) begin
      r = VALUE_W'(size - PANEL_W'(1));
    end else begin
      r = VALUE_W'(v[COORD_W-2:0]);
    end
    return r;
  endfunction

  function automatic logic [TYPE_W-1:0] type_of(input kind_t k);
    logic [TYPE_W-1:0] t;
    unique case (k)
      KIND_ABS_X, KIND_ABS_Y: t = EV_ABS;
      KIND_TOUCH:             t = EV_KEY;
      default:                t = EV_SYN;
    endcase
    return t;
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input kind_t k);
    logic [CODE_W-1:0] c;
    unique case (k)
      KIND_ABS_X: c = CODE_ABS_X;
      KIND_ABS_Y: c = CODE_ABS_Y;
      KIND_TOUCH: c = CODE_BTN_TOUCH;
      default:    c = CODE_SYN_REPORT;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/touch_event_ring_unit.sv
// Top level of the touch event ring: joins controller and datapath.
// Depends on ter_pkg, ter_ctrl and ter_datapath.
//
// Use: drive command and its fields with start high; a request is taken on a
// rising edge with start high and busy low. Reports and opens give no result;
// reads and polls give one result, shown for one cycle with done high.
// Results cannot be held off by the receiver.
// A touch report keeps busy high through S_DIV, which waits for the
// seconds split (four 16-bit quotient digits) to finish, and then through
// four ring writes through the single write port.
// A read keeps busy high in S_RD_CHECK and, when the ring is not empty,
// in S_RD_OUT, after the registered ring read; the result is registered
// after the last of these. Poll and open are taken in the idle state and
// leave busy low; the poll result follows on the next cycle.
// Panel size is written on the config channel (index 0 width, 1 height)
// while busy is low; a zero value is ignored.
// Reset (rst, synchronous) empties the ring, parks the reader at the head,
// clears the overrun flag and sets the panel to 480 by 272.
module touch_event_ring_unit
  import ter_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic signed [COORD_W-1:0]  touch_x,
  input  logic signed [COORD_W-1:0]  touch_y,
  input  logic                       pressed,
  input  logic [TIME_W-1:0]          time_us,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [PANEL_W-1:0]         cfg_data,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       data_ready,
  output logic [TYPE_W-1:0]          event_type,
  output logic [CODE_W-1:0]          event_code,
  output logic [VALUE_W-1:0]         event_value,
  output logic [SEC_W-1:0]           event_seconds,
  output logic [USEC_W-1:0]          event_microseconds,
  output logic                       overrun_seen
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign cfg_ready = ~busy;

  ter_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  ter_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .touch_x            (touch_x),
    .touch_y            (touch_y),
    .pressed            (pressed),
    .time_us            (time_us),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .done               (done),
    .status             (status),
    .data_ready         (data_ready),
    .event_type         (event_type),
    .event_code         (event_code),
    .event_value        (event_value),
    .event_seconds      (event_seconds),
    .event_microseconds (event_microseconds),
    .overrun_seen       (overrun_seen)
  );

endmodule

// File: rtl/ter_divider.sv
// Seconds splitter: divides a 64-bit microsecond time by one million in
// 16-bit digits by reciprocal multiplication, giving seconds (low 32 bits)
// and microseconds. Depends on ter_pkg.
module ter_divider
  import ter_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [TIME_W-1:0]   dividend,
  output logic                done,
  output logic [SEC_W-1:0]    quot,
  output logic [USEC_W-1:0]   rem
);

  logic [TIME_W-1:0]      dq;
  logic [DIV_ODD_W-1:0]   rem_r;
  logic [DIV_DIGIT_W-1:0] digit;
  logic [DIV_SHIFT-1:0]   low_bits;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   run;
  logic [DIV_NUM_W-1:0]   num;
  logic [DIV_PROD_W-1:0]  prod;
  logic [DIV_NUM_W-1:0]   back;
  logic [DIV_NUM_W-1:0]   rem_full;

  // partial remainder joined with the next digit of t >> 6
  assign num      = {rem_r, dq[TIME_W-1 -: DIV_DIGIT_W]};
  assign prod     = DIV_PROD_W'(num) * DIV_PROD_W'(RECIP_M);
  assign back     = DIV_NUM_W'(digit) * DIV_NUM_W'(DIV_ODD);
  assign rem_full = num - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // even step: quotient digit; odd step: new remainder, digit shifted in
  always_ff @(posedge clk) begin
    if (start) begin
      dq       <= TIME_W'(dividend[TIME_W-1:DIV_SHIFT]);
      rem_r    <= '0;
      low_bits <= dividend[DIV_SHIFT-1:0];
    end else if (run) begin
      if (!cnt[0]) begin
        digit <= prod[RECIP_SHIFT +: DIV_DIGIT_W];
      end else begin
        rem_r <= rem_full[DIV_ODD_W-1:0];
        dq    <= {dq[TIME_W-DIV_DIGIT_W-1:0], digit};
      end
    end
  end

  assign quot = dq[SEC_W-1:0];
  assign rem  = {rem_r, low_bits};

endmodule

// File: rtl/ter_datapath.sv
// Datapath: panel registers, event ring memory, head/cursor counters,
// overrun flag and result registers. Depends on ter_pkg and ter_divider.
`include "assert_macros.svh"

module ter_datapath
  import ter_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 stat,
  input  logic signed [COORD_W-1:0]  touch_x,
  input  logic signed [COORD_W-1:0]  touch_y,
  input  logic                       pressed,
  input  logic [TIME_W-1:0]          time_us,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [PANEL_W-1:0]         cfg_data,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       data_ready,
  output logic [TYPE_W-1:0]          event_type,
  output logic [CODE_W-1:0]          event_code,
  output logic [VALUE_W-1:0]         event_value,
  output logic [SEC_W-1:0]           event_seconds,
  output logic [USEC_W-1:0]          event_microseconds,
  output logic                       overrun_seen
);

  logic [PANEL_W-1:0] panel_width;
  logic [PANEL_W-1:0] panel_height;
  logic [CNT_W-1:0]   produced;
  logic [CNT_W-1:0]   cursor;
  logic               overrun;
  logic [VALUE_W-1:0] x_clamp;
  logic [VALUE_W-1:0] y_clamp;
  logic               touch_pressed;
  event_t             ring [RING_DEPTH];
  event_t             rd_data;
  event_t             wr_event;
  status_t            status_r;
  logic [CNT_W-1:0]   lag;
  logic               lapped;
  logic               div_done;
  logic [SEC_W-1:0]   div_quot;
  logic [USEC_W-1:0]  div_rem;

  ter_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (time_us),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign lag         = produced - cursor;
  assign lapped      = lag > CNT_W'(RING_DEPTH);
  assign stat.div_done = div_done;
  assign stat.empty    = (cursor == produced);

  // config: a zero size is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RESET;
      panel_height <= PANEL_HEIGHT_RESET;
    end else if (cfg_we && (cfg_data != '0)) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_clamp       <= clamp_axis(touch_x, panel_width);
      y_clamp       <= clamp_axis(touch_y, panel_height);
      touch_pressed <= pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      produced <= '0;
      cursor   <= '0;
      overrun  <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        produced <= produced + CNT_W'(1);
      end
      if (cmd.open) begin
        cursor  <= produced;
        overrun <= 1'b0;
      end else if (cmd.lap && lapped) begin
        cursor  <= produced - CNT_W'(RING_DEPTH);
        overrun <= 1'b1;
      end else if (cmd.rd_issue) begin
        cursor <= cursor + CNT_W'(1);
      end
    end
  end

  always_comb begin
    wr_event.kind    = cmd.wr_kind;
    wr_event.seconds = div_quot;
    wr_event.micro   = div_rem;
    case (cmd.wr_kind)
      KIND_ABS_X: wr_event.value = x_clamp;
      KIND_ABS_Y: wr_event.value = y_clamp;
      KIND_TOUCH: wr_event.value = {{(VALUE_W-1){1'b0}}, touch_pressed};
      default:    wr_event.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ring[produced[RING_AW-1:0]] <= wr_event;
    end
    if (cmd.rd_issue) begin
      rd_data <= ring[cursor[RING_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_poll | cmd.out_block | cmd.out_event;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_poll || cmd.out_block) begin
      status_r           <= cmd.out_poll ? ST_POLL : ST_WOULD_BLOCK;
      data_ready         <= cmd.out_poll && !stat.empty;
      event_type         <= '0;
      event_code         <= '0;
      event_value        <= '0;
      event_seconds      <= '0;
      event_microseconds <= '0;
      overrun_seen       <= overrun;
    end else if (cmd.out_event) begin
      status_r           <= ST_DELIVERED;
      data_ready         <= 1'b0;
      event_type         <= type_of(rd_data.kind);
      event_code         <= code_of(rd_data.kind);
      event_value        <= rd_data.value;
      event_seconds      <= rd_data.seconds;
      event_microseconds <= rd_data.micro;
      overrun_seen       <= overrun;
    end
  end

  assign status = status_r;

  `TER_ASSERT_NEXT(a_wr_count, cmd.wr_en, produced == $past(produced) + 32'd1, "head did not advance on write")
  `TER_ASSERT_NEXT(a_lap_bound, cmd.lap, (produced - cursor) <= 32'(RING_DEPTH), "reader still lapped")
  `TER_ASSERT(a_div_rem, div_done |-> (div_rem < US_PER_SEC), "divider remainder out of range")

endmodule

// File: rtl/ter_ctrl.sv
// Controller FSM for the touch event ring: sequences divide, ring writes
// and reads. Depends on ter_pkg.
module ter_ctrl
  import ter_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  dp_status_t stat,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(command))
            CMD_REPORT: state_next = S_DIV;
            CMD_READ:   state_next = S_RD_CHECK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_DIV:      if (stat.div_done) state_next = S_WR_X;
      S_WR_X:     state_next = S_WR_Y;
      S_WR_Y:     state_next = S_WR_TOUCH;
      S_WR_TOUCH: state_next = S_WR_SYNC;
      S_WR_SYNC:  state_next = S_IDLE;
      S_RD_CHECK: state_next = stat.empty ? S_IDLE : S_RD_OUT;
      S_RD_OUT:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wr_kind = KIND_ABS_X;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(command))
            CMD_REPORT: begin
              cmd.capture   = 1'b1;
              cmd.div_start = 1'b1;
            end
            CMD_OPEN: cmd.open     = 1'b1;
            CMD_READ: cmd.lap      = 1'b1;
            default:  cmd.out_poll = 1'b1;
          endcase
        end
      end
      S_WR_X: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = KIND_ABS_X;
      end
      S_WR_Y: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = KIND_ABS_Y;
      end
      S_WR_TOUCH: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = KIND_TOUCH;
      end
      S_WR_SYNC: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = KIND_SYNC;
      end
      S_RD_CHECK: begin
        if (stat.empty) begin
          cmd.out_block = 1'b1;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_RD_OUT: cmd.out_event = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: tb/touch_event_ring_unit_test.sv
`timescale 1ns / 100ps
// Testbench for touch_event_ring_unit: directed table then random requests,
// each answer checked against an in-bench model of the ring or a fixed expected answer. Needs ter_pkg.
module touch_event_ring_unit_test;
  import ter_pkg::*;

  typedef struct packed {
    status_t            status;
    logic               data_ready;
    logic [TYPE_W-1:0]  etype;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [SEC_W-1:0]   seconds;
    logic [USEC_W-1:0]  micro;
    logic               overrun;
  } answer_t;

  typedef struct {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      prs;
    logic [TIME_W-1:0]         t;
    int                        reps;
    bit                        fixed;
    answer_t                   want;
  } request_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                command = CMD_POLL;
  logic signed [COORD_W-1:0] touch_x = '0;
  logic signed [COORD_W-1:0] touch_y = '0;
  logic                      pressed = 1'b0;
  logic [TIME_W-1:0]         time_us = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_PANEL_WIDTH;
  logic [PANEL_W-1:0]        cfg_data = '0;
  logic                      done;
  logic [1:0]                status;
  logic                      data_ready;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         event_code;
  logic [VALUE_W-1:0]        event_value;
  logic [SEC_W-1:0]          event_seconds;
  logic [USEC_W-1:0]         event_microseconds;
  logic                      overrun_seen;

  touch_event_ring_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // model of the ring
  kind_t              ring_kind  [RING_DEPTH];
  logic [VALUE_W-1:0] ring_value [RING_DEPTH];
  logic [SEC_W-1:0]   ring_sec   [RING_DEPTH];
  logic [USEC_W-1:0]  ring_usec  [RING_DEPTH];
  logic [CNT_W-1:0]   head_count = '0;
  logic [CNT_W-1:0]   read_pos = '0;
  logic               lapped = 1'b0;
  logic [PANEL_W-1:0] width_reg = PANEL_WIDTH_RESET;
  logic [PANEL_W-1:0] height_reg = PANEL_HEIGHT_RESET;

  answer_t  pending_answers[$];
  request_t directed[$];
  int       errors = 0;
  int       quiet_cycles = 0;

  function automatic logic [VALUE_W-1:0] limit_to_panel(logic signed [COORD_W-1:0] v,
                                                         logic [PANEL_W-1:0] size);
    int iv;
    iv = v;
    if (iv < 0) return '0;
    if (iv >= int'(size)) return size - 1'b1;
    return VALUE_W'(iv);
  endfunction

  function automatic void store_event(kind_t k, logic [VALUE_W-1:0] v,
                                      logic [SEC_W-1:0] s, logic [USEC_W-1:0] u);
    int slot;
    slot = head_count % RING_DEPTH;
    ring_kind[slot]  = k;
    ring_value[slot] = v;
    ring_sec[slot]   = s;
    ring_usec[slot]  = u;
    head_count++;
  endfunction

  function automatic bit predict_ring(input request_t r, output answer_t a);
    logic [TIME_W-1:0] q;
    logic [SEC_W-1:0]  s;
    logic [USEC_W-1:0] u;
    int                slot;
    a = '0;
    case (r.cmd)
      CMD_REPORT: begin
        q = r.t / 64'd1000000;
        s = q[SEC_W-1:0];
        q = r.t % 64'd1000000;
        u = q[USEC_W-1:0];
        store_event(KIND_ABS_X, limit_to_panel(r.x, width_reg), s, u);
        store_event(KIND_ABS_Y, limit_to_panel(r.y, height_reg), s, u);
        store_event(KIND_TOUCH, VALUE_W'(r.prs), s, u);
        store_event(KIND_SYNC, '0, s, u);
        return 1'b0;
      end
      CMD_OPEN: begin
        read_pos = head_count;
        lapped = 1'b0;
        return 1'b0;
      end
      CMD_POLL: begin
        a.status = ST_POLL;
        a.data_ready = (read_pos != head_count);
        a.overrun = lapped;
        return 1'b1;
      end
      default: begin
        if (head_count - read_pos > CNT_W'(RING_DEPTH)) begin
          read_pos = head_count - CNT_W'(RING_DEPTH);
          lapped = 1'b1;
        end
        a.overrun = lapped;
        if (read_pos == head_count) begin
          a.status = ST_WOULD_BLOCK;
          return 1'b1;
        end
        slot = read_pos % RING_DEPTH;
        a.status = ST_DELIVERED;
        case (ring_kind[slot])
          KIND_ABS_X: begin a.etype = EV_ABS; a.code = CODE_ABS_X; end
          KIND_ABS_Y: begin a.etype = EV_ABS; a.code = CODE_ABS_Y; end
          KIND_TOUCH: begin a.etype = EV_KEY; a.code = CODE_BTN_TOUCH; end
          default:    begin a.etype = EV_SYN; a.code = CODE_SYN_REPORT; end
        endcase
        a.value   = ring_value[slot];
        a.seconds = ring_sec[slot];
        a.micro   = ring_usec[slot];
        read_pos++;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic request_t req(cmd_t c, int x, int y, logic p, logic [TIME_W-1:0] t,
                                   int reps);
    request_t r;
    r.cmd = c; r.x = COORD_W'(x); r.y = COORD_W'(y); r.prs = p; r.t = t;
    r.reps = reps; r.fixed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic request_t req_fixed(cmd_t c, status_t s, logic dr,
                                         logic [TYPE_W-1:0] ty, logic [CODE_W-1:0] cd,
                                         logic ov);
    request_t r;
    r = req(c, 0, 0, 1'b0, '0, 1);
    r.fixed = 1'b1;
    r.want.status = s;
    r.want.data_ready = dr;
    r.want.etype = ty;
    r.want.code = cd;
    r.want.overrun = ov;
    return r;
  endfunction

  function automatic request_t random_request(bit read_heavy);
    request_t r;
    int       pick;
    r = req(CMD_POLL, 0, 0, 1'b0, '0, 1);
    pick = $urandom_range(99);
    if (read_heavy)
      r.cmd = (pick < 15) ? CMD_REPORT : (pick < 20) ? CMD_OPEN : (pick < 35) ? CMD_POLL
                                                                              : CMD_READ;
    else
      r.cmd = (pick < 40) ? CMD_REPORT : (pick < 45) ? CMD_OPEN : (pick < 55) ? CMD_POLL
                                                                              : CMD_READ;
    case ($urandom_range(2))
      0: begin r.x = COORD_W'($urandom); r.y = COORD_W'($urandom); end
      1: begin
        r.x = COORD_W'($urandom_range(0, width_reg + 2));
        r.y = COORD_W'($urandom_range(0, height_reg + 2));
      end
      default: begin
        r.x = COORD_W'(int'($urandom_range(0, 3)) - 2);
        r.y = COORD_W'(int'($urandom_range(0, 3)) - 2);
      end
    endcase
    r.prs = 1'($urandom_range(1));
    if ($urandom_range(1)) r.t = {$urandom, $urandom};
    else r.t = TIME_W'($urandom_range(0, 5000000));
    return r;
  endfunction

  task automatic send_request(input request_t r);
    answer_t a;
    start   <= 1'b1;
    command <= r.cmd;
    touch_x <= r.x;
    touch_y <= r.y;
    pressed <= r.prs;
    time_us <= r.t;
    do @(posedge clk); while (busy);
    if (predict_ring(r, a)) pending_answers.push_back(r.fixed ? r.want : a);
  endtask

  task automatic pause_sender(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [PANEL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (v != '0) begin
      if (idx == CFG_PANEL_WIDTH) width_reg = v;
      else height_reg = v;
    end
  endtask

  task automatic set_panel(logic [PANEL_W-1:0] w, logic [PANEL_W-1:0] h);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    while (busy) @(posedge clk);
    write_reg(CFG_PANEL_WIDTH, w);
    write_reg(CFG_PANEL_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_t w;
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t unexpected answer: expected none, got status %0d", $time, status);
      end else begin
        w = pending_answers.pop_front();
        check_field("status", w.status, status);
        check_field("data_ready", w.data_ready, data_ready);
        check_field("event_type", w.etype, event_type);
        check_field("event_code", w.code, event_code);
        check_field("event_value", w.value, event_value);
        check_field("event_seconds", w.seconds, event_seconds);
        check_field("event_microseconds", w.micro, event_microseconds);
        check_field("overrun_seen", w.overrun, overrun_seen);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 2000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit read_heavy;
    int ph;
    int n;
    int k;
    int idle_pct;
    directed.push_back(req_fixed(CMD_READ, ST_WOULD_BLOCK, 1'b0, EV_SYN, '0, 1'b0));
    directed.push_back(req_fixed(CMD_POLL, ST_POLL, 1'b0, EV_SYN, '0, 1'b0));
    directed.push_back(req(CMD_REPORT, -32768, -32768, 1'b0, '0, 1));
    directed.push_back(req_fixed(CMD_READ, ST_DELIVERED, 1'b0, EV_ABS, CODE_ABS_X, 1'b0));
    directed.push_back(req_fixed(CMD_READ, ST_DELIVERED, 1'b0, EV_ABS, CODE_ABS_Y, 1'b0));
    directed.push_back(req_fixed(CMD_READ, ST_DELIVERED, 1'b0, EV_KEY, CODE_BTN_TOUCH, 1'b0));
    directed.push_back(req_fixed(CMD_READ, ST_DELIVERED, 1'b0, EV_SYN, CODE_SYN_REPORT, 1'b0));
    directed.push_back(req_fixed(CMD_READ, ST_WOULD_BLOCK, 1'b0, EV_SYN, '0, 1'b0));
    directed.push_back(req(CMD_REPORT, 32767, 32767, 1'b1, '1, 1));
    directed.push_back(req_fixed(CMD_POLL, ST_POLL, 1'b1, EV_SYN, '0, 1'b0));
    directed.push_back(req(CMD_READ, 0, 0, 1'b0, '0, 4));
    directed.push_back(req(CMD_REPORT, 0, 0, 1'b1, 64'd999999, 1));
    directed.push_back(req(CMD_REPORT, 479, 271, 1'b0, 64'd1000000, 1));
    directed.push_back(req(CMD_REPORT, -1, 480, 1'b1, 64'd1000000000123, 1));
    directed.push_back(req(CMD_READ, 0, 0, 1'b0, '0, 12));
    directed.push_back(req(CMD_OPEN, 0, 0, 1'b0, '0, 1));
    directed.push_back(req_fixed(CMD_READ, ST_WOULD_BLOCK, 1'b0, EV_SYN, '0, 1'b0));
    // 17 reports after the open: writer laps the reader
    directed.push_back(req(CMD_REPORT, 1234, 200, 1'b1, 64'd123456789012, 17));
    directed.push_back(req_fixed(CMD_POLL, ST_POLL, 1'b1, EV_SYN, '0, 1'b0));
    directed.push_back(req(CMD_READ, 0, 0, 1'b0, '0, 3));
    directed.push_back(req_fixed(CMD_POLL, ST_POLL, 1'b1, EV_SYN, '0, 1'b1));
    directed.push_back(req(CMD_OPEN, 0, 0, 1'b0, '0, 1));
    directed.push_back(req_fixed(CMD_POLL, ST_POLL, 1'b0, EV_SYN, '0, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // zero sizes must leave the reset panel in place
    set_panel('0, '0);
    foreach (directed[i]) begin
      for (k = 0; k < directed[i].reps; k++) begin
        send_request(directed[i]);
        pause_sender(12);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_panel(12'd1, 12'd4095);
        1: set_panel(12'd4095, 12'd1);
        2: set_panel('0, PANEL_W'($urandom_range(1, 4095)));
        3: set_panel(PANEL_W'($urandom_range(1, 4095)), '0);
        default: set_panel(PANEL_W'($urandom_range(1, 4095)),
                           PANEL_W'($urandom_range(1, 4095)));
      endcase
      idle_pct = (ph < 2) ? 12 : (ph < 4) ? 56 : 0;
      read_heavy = 1'b0;
      for (n = 0; n < 150; n++) begin
        if (n % 32 == 0) read_heavy = 1'($urandom_range(1));
        send_request(random_request(read_heavy));
        pause_sender(idle_pct);
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ter_pkg.sv
rtl/ter_divider.sv
rtl/ter_datapath.sv
rtl/ter_ctrl.sv
rtl/touch_event_ring_unit.sv
tb/touch_event_ring_unit_test.sv
